// ===== sv/pcgbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbr_pkg
// Types, constants and helper functions for the PCG32 bounded random block.
// ----------------------------------------------------------------------------
package pcgbr_pkg;

    localparam int StateW   = 64;
    localparam int HalfW    = StateW / 2;
    localparam int ValueW   = 32;
    localparam int StreamW  = 63;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 64;

    localparam logic [StateW-1:0] LcgMult = 64'd6364136223846793005;
    localparam logic [HalfW-1:0]  MultLo  = LcgMult[HalfW-1:0];
    localparam logic [HalfW-1:0]  MultHi  = LcgMult[StateW-1:HalfW];

    localparam int XsShift   = 18;
    localparam int MixShift  = 27;
    localparam int RotShift  = 59;

    // advance sequence: three partial products, two accumulates, one add
    localparam int AdvCntW = 3;
    localparam logic [AdvCntW-1:0] AdvLast = 3'd4;

    // remainder unit retires two dividend bits per cycle
    localparam int DivBitsPerCycle = 2;
    localparam int DivCntW = $clog2(ValueW / DivBitsPerCycle);
    localparam logic [DivCntW-1:0] DivLast = DivCntW'(ValueW / DivBitsPerCycle - 1);

    localparam logic [ValueW-1:0] ZeroValue = '0;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INITIAL_STATE = 1'b0,
        CFG_STREAM_SELECT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        FUNC_DRAW   = 1'b0,
        FUNC_RESEED = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        MODE_RESEED = 2'd0,
        MODE_RAW    = 2'd1,
        MODE_BOUND  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ADV  = 3'd1,
        ST_DIV  = 3'd2,
        ST_DONE = 3'd3
    } fsm_t;

    // XSH-RR output permutation of the pre-advance state
    function automatic logic [ValueW-1:0] xsh_rr(input logic [StateW-1:0] s);
        logic [StateW-1:0]   xs;
        logic [ValueW-1:0]   mixed;
        logic [4:0]          rot;
        logic [2*ValueW-1:0] dbl;
        xs    = s ^ (s >> XsShift);
        mixed = xs[MixShift +: ValueW];
        rot   = s[RotShift +: 5];
        dbl   = {mixed, mixed} >> rot;
        return dbl[ValueW-1:0];
    endfunction

    // one restoring division step
    function automatic logic [ValueW-1:0] div_step(
        input logic [ValueW-1:0] rem,
        input logic              din,
        input logic [ValueW-1:0] dsr
    );
        logic [ValueW:0] t;
        t = {rem, din};
        if (t >= {1'b0, dsr})
            t = t - {1'b0, dsr};
        return t[ValueW-1:0];
    endfunction

endpackage : pcgbr_pkg
`default_nettype wire

// ===== sv/pcgbr_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbr_if
// Valid/ready channels: request items (func, bound) and result items (value).
// ----------------------------------------------------------------------------
interface pcgbr_req_if import pcgbr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              func;
    logic [ValueW-1:0] bound;

    modport source (output valid, output func, output bound, input ready);
    modport sink   (input valid, input func, input bound, output ready);
endinterface : pcgbr_req_if

interface pcgbr_rsp_if import pcgbr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ValueW-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface : pcgbr_rsp_if
`default_nettype wire

// ===== sv/pcg32_bounded_random_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_bounded_random_top
// PCG32 XSH-RR generator with unbiased bounded draws and reseed.
// ----------------------------------------------------------------------------
// One item at a time. A reseed or a draw with bound 0 is accepted, runs one
// state advance and hands off its result. A draw with a nonzero bound computes
// the rejection threshold, runs one state advance per generated output (more
// if outputs are rejected) and computes the final remainder. The state advance
// runs three 32x32 partial products through one shared multiplier;
// threshold and remainder share one remainder unit that
// retires two dividend bits per cycle. A finished result waits in the output
// register while the next item is accepted.
module pcg32_bounded_random_top import pcgbr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    pcgbr_req_if.sink                req,
    pcgbr_rsp_if.source              rsp
);

    fsm_t                 fsm_reg, fsm_next;
    mode_t                mode_reg, mode_next;
    logic [AdvCntW-1:0]   adv_cnt_reg, adv_cnt_next;
    logic [DivCntW-1:0]   div_cnt_reg, div_cnt_next;
    logic                 thr_phase_reg, thr_phase_next;
    logic                 out_valid_reg, out_valid_next;

    logic [StateW-1:0]    init_state_reg, init_state_next;
    logic [StreamW-1:0]   stream_reg, stream_next;
    logic [StateW-1:0]    lcg_state_reg, lcg_state_next;
    logic [StateW-1:0]    lcg_inc_reg, lcg_inc_next;

    logic [ValueW-1:0]    bound_reg, bound_next;
    logic [ValueW-1:0]    raw_reg, raw_next;
    logic [StateW-1:0]    prod_reg, prod_next;
    logic [StateW-1:0]    acc_reg, acc_next;
    logic [ValueW-1:0]    rem_reg, rem_next;
    logic [ValueW-1:0]    dvd_reg, dvd_next;
    logic [ValueW-1:0]    thr_reg, thr_next;
    logic [ValueW-1:0]    res_reg, res_next;
    logic [ValueW-1:0]    out_value_reg, out_value_next;

    logic [HalfW-1:0]     mul_a, mul_b;
    logic [ValueW-1:0]    rem_half, rem_full;
    logic                 req_fire, adv_last, div_last, raw_ok, out_free;

    assign req.ready = (fsm_reg == ST_IDLE);
    assign req_fire  = req.valid && (fsm_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

    assign adv_last = (adv_cnt_reg == AdvLast);
    assign div_last = (div_cnt_reg == DivLast);
    assign raw_ok   = (raw_reg >= thr_reg);
    assign out_free = !out_valid_reg || rsp.ready;

    assign rem_half = div_step(rem_reg, dvd_reg[ValueW-1], bound_reg);
    assign rem_full = div_step(rem_half, dvd_reg[ValueW-2], bound_reg);

    // shared multiplier operand select
    always_comb
    begin
        case (adv_cnt_reg)
            3'd0:
            begin
                mul_a = lcg_state_reg[HalfW-1:0];
                mul_b = MultLo;
            end
            3'd1:
            begin
                mul_a = lcg_state_reg[StateW-1:HalfW];
                mul_b = MultLo;
            end
            default:
            begin
                mul_a = lcg_state_reg[HalfW-1:0];
                mul_b = MultHi;
            end
        endcase
    end

    // next state
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.func == FUNC_RESEED || req.bound == ZeroValue)
                        fsm_next = ST_ADV;
                    else
                        fsm_next = ST_DIV;
                end
            end
            ST_ADV:
            begin
                if (adv_last)
                begin
                    if (mode_reg != MODE_BOUND)
                        fsm_next = ST_DONE;
                    else if (raw_ok)
                        fsm_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                    fsm_next = thr_phase_reg ? ST_ADV : ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    fsm_next = ST_IDLE;
            end
            default: fsm_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next       = mode_reg;
        adv_cnt_next    = adv_cnt_reg;
        div_cnt_next    = div_cnt_reg;
        thr_phase_next  = thr_phase_reg;
        out_valid_next  = out_valid_reg;
        init_state_next = init_state_reg;
        stream_next     = stream_reg;
        lcg_state_next  = lcg_state_reg;
        lcg_inc_next    = lcg_inc_reg;
        bound_next      = bound_reg;
        raw_next        = raw_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        thr_next        = thr_reg;
        res_next        = res_reg;
        out_value_next  = out_value_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_INITIAL_STATE)
                init_state_next = cfg_data;
            else if (cfg_index == CFG_STREAM_SELECT)
                stream_next = cfg_data[StreamW-1:0];
        end

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    bound_next   = req.bound;
                    adv_cnt_next = '0;
                    div_cnt_next = '0;
                    if (req.func == FUNC_RESEED)
                    begin
                        // advancing from a zero state just yields the increment
                        mode_next      = MODE_RESEED;
                        lcg_inc_next   = {stream_reg, 1'b1};
                        lcg_state_next = {stream_reg, 1'b1} + init_state_reg;
                    end
                    else if (req.bound == ZeroValue)
                    begin
                        mode_next = MODE_RAW;
                    end
                    else
                    begin
                        mode_next      = MODE_BOUND;
                        thr_phase_next = 1'b1;
                        rem_next       = '0;
                        dvd_next       = ~req.bound + 1'b1;
                    end
                end
            end
            ST_ADV:
            begin
                adv_cnt_next = adv_cnt_reg + 1'b1;
                prod_next    = StateW'(mul_a) * StateW'(mul_b);
                case (adv_cnt_reg)
                    3'd0: raw_next = xsh_rr(lcg_state_reg);
                    3'd1: acc_next = prod_reg;
                    3'd2,
                    3'd3: acc_next = acc_reg + {prod_reg[HalfW-1:0], {HalfW{1'b0}}};
                    default:
                    begin
                        lcg_state_next = acc_reg + lcg_inc_reg;
                        adv_cnt_next   = '0;
                        if (mode_reg == MODE_RESEED)
                            res_next = ZeroValue;
                        else if (mode_reg == MODE_RAW)
                            res_next = raw_reg;
                        else if (raw_ok)
                        begin
                            thr_phase_next = 1'b0;
                            div_cnt_next   = '0;
                            rem_next       = '0;
                            dvd_next       = raw_reg;
                        end
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_next     = rem_full;
                dvd_next     = dvd_reg << DivBitsPerCycle;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_last)
                begin
                    if (thr_phase_reg)
                        thr_next = rem_full;
                    else
                        res_next = rem_full;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_value_next = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= ST_IDLE;
            mode_reg       <= MODE_RAW;
            adv_cnt_reg    <= '0;
            div_cnt_reg    <= '0;
            thr_phase_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            init_state_reg <= '0;
            stream_reg     <= '0;
            lcg_state_reg  <= '0;
            lcg_inc_reg    <= StateW'(1);
        end
        else
        begin
            fsm_reg        <= fsm_next;
            mode_reg       <= mode_next;
            adv_cnt_reg    <= adv_cnt_next;
            div_cnt_reg    <= div_cnt_next;
            thr_phase_reg  <= thr_phase_next;
            out_valid_reg  <= out_valid_next;
            init_state_reg <= init_state_next;
            stream_reg     <= stream_next;
            lcg_state_reg  <= lcg_state_next;
            lcg_inc_reg    <= lcg_inc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg     <= bound_next;
        raw_reg       <= raw_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        dvd_reg       <= dvd_next;
        thr_reg       <= thr_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
    end

`ifndef SYNTHESIS
    a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_inc_reg[0])
        else $error("increment lost its odd bit");

    a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_DIV) |-> (rem_reg < bound_reg))
        else $error("partial remainder not below bound");

    a_result_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_DONE && mode_reg == MODE_BOUND) |-> (res_reg < bound_reg))
        else $error("bounded result out of range");

    a_reseed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_DONE && mode_reg == MODE_RESEED) |-> (res_reg == ZeroValue))
        else $error("reseed result not zero");

    a_adv_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_ADV && !adv_last) |=> (fsm_reg == ST_ADV))
        else $error("advance sequence cut short");
`endif

endmodule : pcg32_bounded_random_top
`default_nettype wire
